// ----- design/gap_buffer_text_store_assert.svh -----
// Assertion macros for the gap buffer text store.
`ifndef GAP_BUFFER_TEXT_STORE_ASSERT_SVH
`define GAP_BUFFER_TEXT_STORE_ASSERT_SVH
// Assert that a condition implies another at the same edge.
`define GBTS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Assert that a condition holds at every edge.
`define GBTS_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`endif

// ----- design/gbts_pkg.sv -----
// Package with shared types and constants for the gap buffer text store.
package gbts_pkg;
    localparam int CAPACITY_DEF = 4096;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_FIND   = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [12:0] place;
        logic [12:0] range_stop;
        logic [7:0]  symbol;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] found_place;
        logic [7:0]  read_symbol;
        logic [12:0] text_length;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE, S_MOVE_FWD, S_MOVE_BACK, S_SCAN, S_READ, S_FINISH
    } eng_state_t;
endpackage

// ----- design/gbts_cmd_queue.sv -----
// Small command queue between the front end and the engine.
module gbts_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  gbts_pkg::cmd_t wdata,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output gbts_pkg::cmd_t rdata
);
    gbts_pkg::cmd_t slot_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign rdata = slot_reg[rptr_reg];

    // Store pushed commands.
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

    // Advance pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop && !empty)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + 2'((push && !full) ? 1 : 0)
                                   - 2'((pop && !empty) ? 1 : 0);
        end
    end
endmodule

// ----- design/gbts_engine.sv -----
// Back end: gap moves, scans and reads over the byte memory.
module gbts_engine #(
    parameter int CAPACITY = gbts_pkg::CAPACITY_DEF,
    parameter int AW = $clog2(CAPACITY),
    parameter int LW = AW + 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  gbts_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           res_valid,
    output gbts_pkg::res_t res,
    input  logic           res_pop
);
    localparam logic [LW-1:0] CAP = LW'(CAPACITY);

    logic [7:0] mem [CAPACITY];
    logic [7:0] rd_q;

    gbts_pkg::eng_state_t state_reg, state_next;
    logic [LW-1:0] gb_reg, gb_next, gf_reg, gf_next;
    logic [LW-1:0] tgt_reg, tgt_next, idx_reg, idx_next, stop_reg, stop_next;
    gbts_pkg::cmd_t cur_reg, cur_next;
    logic           pend_reg, pend_next;
    gbts_pkg::res_t res_reg, res_next;
    logic           rv_reg, rv_next;

    logic [LW-1:0] len, gsz, plc, stp, pidx;
    logic          we;
    logic [AW-1:0] wa, ra;
    logic [7:0]    wd;

    assign gsz = gf_reg - gb_reg;
    assign len = CAP - gsz;
    // Clamp incoming positions to the text length (ports are 13 bits).
    always_comb
    begin
        logic [LW:0] p, s;
        p = (LW+1)'(cmd.place);
        s = (LW+1)'(cmd.range_stop);
        plc = (p > {1'b0, len}) ? len : p[LW-1:0];
        stp = (s > {1'b0, len}) ? len : s[LW-1:0];
    end
    assign pidx = (idx_reg < gb_reg) ? idx_reg : idx_reg + gsz;

    assign res_valid = rv_reg;
    assign res       = res_reg;

    // Memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_q <= mem[ra];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gbts_pkg::S_IDLE:
            begin
                if (cmd_valid && !rv_reg)
                begin
                    case (cmd.cmd)
                        gbts_pkg::CMD_INSERT:
                            state_next = (gsz == '0) ? gbts_pkg::S_FINISH
                                       : (plc > gb_reg) ? gbts_pkg::S_MOVE_FWD
                                       : (plc < gb_reg) ? gbts_pkg::S_MOVE_BACK
                                       : gbts_pkg::S_FINISH;
                        gbts_pkg::CMD_DELETE:
                            state_next = (plc >= stp) ? gbts_pkg::S_FINISH
                                       : (stp > gb_reg) ? gbts_pkg::S_MOVE_FWD
                                       : (stp < gb_reg) ? gbts_pkg::S_MOVE_BACK
                                       : gbts_pkg::S_FINISH;
                        gbts_pkg::CMD_FIND:
                            state_next = (plc >= len) ? gbts_pkg::S_FINISH
                                                      : gbts_pkg::S_SCAN;
                        default:
                            state_next = (plc >= len) ? gbts_pkg::S_FINISH
                                                      : gbts_pkg::S_READ;
                    endcase
                end
            end
            gbts_pkg::S_MOVE_FWD:
                if (gb_reg + 1'b1 >= tgt_reg && pend_reg) state_next = gbts_pkg::S_FINISH;
            gbts_pkg::S_MOVE_BACK:
                if (gb_reg - 1'b1 <= tgt_reg && pend_reg) state_next = gbts_pkg::S_FINISH;
            gbts_pkg::S_SCAN:
                if (pend_reg && (rd_q == cur_reg.symbol || idx_reg >= len))
                    state_next = gbts_pkg::S_FINISH;
            gbts_pkg::S_READ:
                if (pend_reg) state_next = gbts_pkg::S_FINISH;
            gbts_pkg::S_FINISH:
                state_next = gbts_pkg::S_IDLE;
            default:
                state_next = gbts_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        gb_next = gb_reg; gf_next = gf_reg; tgt_next = tgt_reg;
        idx_next = idx_reg; stop_next = stop_reg; cur_next = cur_reg;
        pend_next = 1'b0; res_next = res_reg; rv_next = rv_reg;
        cmd_pop = 1'b0; we = 1'b0; wa = '0; wd = rd_q; ra = '0;
        if (res_pop && rv_reg)
        begin
            rv_next = 1'b0;
        end
        case (state_reg)
            gbts_pkg::S_IDLE:
            begin
                if (cmd_valid && !rv_reg)
                begin
                    cmd_pop  = 1'b1;
                    cur_next = cmd;
                    cur_next.place = 13'(plc);
                    stop_next = stp;
                    idx_next = plc;
                    tgt_next = (cmd.cmd == gbts_pkg::CMD_DELETE) ? stp : plc;
                end
            end
            gbts_pkg::S_MOVE_FWD:
            begin
                // Read byte after gap, then write it to gap start.
                if (!pend_reg)
                begin
                    ra = gf_reg[AW-1:0];
                    pend_next = 1'b1;
                end
                else
                begin
                    we = 1'b1; wa = gb_reg[AW-1:0];
                    gb_next = gb_reg + 1'b1; gf_next = gf_reg + 1'b1;
                end
            end
            gbts_pkg::S_MOVE_BACK:
            begin
                if (!pend_reg)
                begin
                    ra = AW'(gb_reg - 1'b1);
                    pend_next = 1'b1;
                end
                else
                begin
                    we = 1'b1; wa = AW'(gf_reg - 1'b1);
                    gb_next = gb_reg - 1'b1; gf_next = gf_reg - 1'b1;
                end
            end
            gbts_pkg::S_SCAN, gbts_pkg::S_READ:
            begin
                // Issue the address, then test the returned byte; hold the address meanwhile.
                ra = pidx[AW-1:0];
                if (!pend_reg)
                begin
                    pend_next = 1'b1;
                end
                else if (state_reg == gbts_pkg::S_SCAN && rd_q != cur_reg.symbol)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            gbts_pkg::S_FINISH:
            begin
                res_next = '0;
                case (cur_reg.cmd)
                    gbts_pkg::CMD_INSERT:
                    begin
                        if (gsz == '0)
                        begin
                            res_next.status = gbts_pkg::ST_FULL;
                        end
                        else
                        begin
                            we = 1'b1; wa = gb_reg[AW-1:0]; wd = cur_reg.symbol;
                            gb_next = gb_reg + 1'b1;
                        end
                    end
                    gbts_pkg::CMD_DELETE:
                    begin
                        if (LW'(cur_reg.place) < stop_reg)
                        begin
                            gb_next = gb_reg - (stop_reg - LW'(cur_reg.place));
                        end
                    end
                    gbts_pkg::CMD_FIND:
                    begin
                        if (idx_reg < len && LW'(cur_reg.place) < len)
                        begin
                            res_next.found_place = 12'(idx_reg);
                        end
                        else
                        begin
                            res_next.status = gbts_pkg::ST_NOTFOUND;
                        end
                    end
                    default:
                    begin
                        if (LW'(cur_reg.place) < len)
                        begin
                            res_next.read_symbol = rd_q;
                        end
                        else
                        begin
                            res_next.status = gbts_pkg::ST_NOTFOUND;
                        end
                    end
                endcase
                res_next.text_length = 13'(CAP - (gf_next - gb_next));
                rv_next = 1'b1;
            end
            default: ;
        endcase
    end

    // Hold registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbts_pkg::S_IDLE;
            gb_reg    <= '0;
            gf_reg    <= CAP;
            pend_reg  <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            gb_reg    <= gb_next;
            gf_reg    <= gf_next;
            pend_reg  <= pend_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_reg  <= tgt_next;
        idx_reg  <= idx_next;
        stop_reg <= stop_next;
        cur_reg  <= cur_next;
        res_reg  <= res_next;
    end
endmodule

// ----- design/gap_buffer_text_store.sv -----
// Top level of the gap buffer text store.
//  channel | direction | handshake    | fields
//  command | in        | push / full  | cmd, place, range_stop, symbol
//  result  | out       | pop / empty  | status, found_place, read_symbol, text_length
// Insert and delete move the gap one byte at a time: read the byte, then write it across.
// Find issues each address and then tests the returned byte; read fetches a single byte.
// The single memory port pair and one result register set the rate.
// Reset is asynchronous; the whole store starts as gap, no clearing pass.
// A waiting result stalls the engine; two commands queue in front of it.
module gap_buffer_text_store #(
    parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  cmd,
    input  logic [12:0] place,
    input  logic [12:0] range_stop,
    input  logic [7:0]  symbol,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [11:0] found_place,
    output logic [7:0]  read_symbol,
    output logic [12:0] text_length
);
    `include "gap_buffer_text_store_assert.svh"

    gbts_pkg::cmd_t in_cmd, q_cmd;
    gbts_pkg::res_t res;
    logic q_empty, q_pop, rv;

    assign in_cmd = '{cmd: cmd, place: place, range_stop: range_stop, symbol: symbol};

    gbts_cmd_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .wdata(in_cmd), .full(full),
        .pop(q_pop), .empty(q_empty), .rdata(q_cmd)
    );

    gbts_engine #(.CAPACITY(CAPACITY)) u_engine (
        .clk(clk), .rst_n(rst_n), .cmd_valid(!q_empty), .cmd(q_cmd),
        .cmd_pop(q_pop), .res_valid(rv), .res(res), .res_pop(pop)
    );

    assign empty       = !rv;
    assign status      = res.status;
    assign found_place = res.found_place;
    assign read_symbol = res.read_symbol;
    assign text_length = res.text_length;

    `GBTS_ASSERT_IMPL(a_pop_needs_cmd, q_pop, !q_empty)
    `GBTS_ASSERT_IMPL(a_status_code, !empty, status != 2'd3)
    `GBTS_ASSERT_ALWAYS(a_len_bound, empty || text_length <= 13'(CAPACITY))
endmodule
